[hdl/led_ppd_pkg.sv]
// Shared types, constants and helpers for the LED pattern and pulse driver.
package led_ppd_pkg;

  // Fixed field and state widths
  localparam int TickW   = 10;
  localparam int StepW   = 5;
  localparam int ModeW   = 2;
  localparam int ValueW  = 8;
  localparam int MsecWrap = 1000;

  // Pattern phases and pulse train length
  localparam int PatternPhases = 8;
  localparam int PhaseW        = $clog2(PatternPhases);
  localparam int MaxPulses     = 6;
  localparam int IdxW          = ($clog2(MaxPulses) > 0) ? $clog2(MaxPulses) : 1;

  // Reciprocal for value mod MaxPulses on an 8-bit value
  localparam int RecipShift = 12;
  localparam int RecipVal   = ((1 << RecipShift) + MaxPulses - 1) / MaxPulses;
  localparam int RecipW     = RecipShift + 1;
  localparam int ProdW      = ValueW + RecipW;

  // Bit-serial divider sizing
  localparam int DivCntW = $clog2(TickW + 1);

  // Register reset values
  localparam logic [TickW-1:0] PatternStepReset = TickW'(125);
  localparam logic [TickW-1:0] PulseStepReset   = TickW'(50);

  // Command codes
  localparam logic [ModeW-1:0] MODE_TICK    = 2'd0;
  localparam logic [ModeW-1:0] MODE_PATTERN = 2'd1;
  localparam logic [ModeW-1:0] MODE_PULSE   = 2'd2;

  // Configuration register map
  localparam int CfgAddrW = 4;
  localparam int CfgIdxW  = 2;
  localparam logic [CfgIdxW-1:0] REG_POLARITY     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_STEP = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PULSE_STEP   = 2'd2;

  // Pattern table: bit p is the entry of phase p, 1 = on
  localparam logic [7:0][PatternPhases-1:0] PATTERN_ROM = {
    8'h00, 8'h00, 8'h15, 8'h05, 8'h55, 8'h33, 8'h0F, 8'hFF
  };

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic pin_level;
    logic pulse_busy;
  } res_t;

  // Divider result toward the core
  typedef struct packed {
    logic              done;
    logic [PhaseW-1:0] phase;
    logic [TickW-1:0]  rem;
  } div_res_t;

  // value mod MaxPulses through a reciprocal multiply
  function automatic logic [IdxW-1:0] pulse_index(input logic [ValueW-1:0] v);
    logic [ProdW-1:0]    prod;
    logic [ValueW:0]     quo;
    logic [ValueW+3:0]   back;
    logic [ValueW-1:0]   rem;
    prod = ProdW'(v) * ProdW'(RecipVal);
    quo  = (ValueW + 1)'(prod >> RecipShift);
    back = (ValueW + 4)'(quo) * (ValueW + 4)'(MaxPulses);
    rem  = v - back[ValueW-1:0];
    return rem[IdxW-1:0];
  endfunction

endpackage

[hdl/led_ppd_div.sv]
// Bit-serial divider that realigns the pattern phase after a step length change.
module led_ppd_div
  import led_ppd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TickW-1:0] dividend,
  input  logic [TickW-1:0] divisor,
  output logic             busy,
  output div_res_t         result
);

  logic [DivCntW-1:0] cnt;
  logic               done;
  logic [TickW-1:0]   rem;
  logic [TickW-1:0]   quo;
  logic [TickW-1:0]   dsr;
  logic [TickW:0]     shifted;
  logic [TickW:0]     diff;
  logic               qbit;
  logic [TickW-1:0]   rem_next;

  // One restoring step per cycle
  always_comb begin
    shifted  = {rem, quo[TickW-1]};
    diff     = shifted - {1'b0, dsr};
    qbit     = (shifted >= {1'b0, dsr});
    rem_next = qbit ? diff[TickW-1:0] : shifted[TickW-1:0];
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DivCntW'(1)) && !start;
      if (start) begin
        cnt <= DivCntW'(TickW);
      end else if (cnt != '0) begin
        cnt <= cnt - DivCntW'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem <= rem_next;
      quo <= {quo[TickW-2:0], qbit};
    end
  end

  assign busy         = (cnt != '0) || done;
  assign result.done  = done;
  assign result.phase = quo[PhaseW-1:0];
  assign result.rem   = rem;

endmodule

[hdl/led_ppd_core.sv]
// Millisecond counter, pattern phase tracking and pulse train sequencing.
module led_ppd_core
  import led_ppd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  cmd_t             cmd,
  input  logic             polarity,
  input  logic [TickW-1:0] pat_len,
  input  logic [TickW-1:0] pul_len,
  input  div_res_t         realign,
  output logic [TickW-1:0] msec,
  output res_t             res_next
);

  logic [TickW-1:0]  msec_count, msec_count_next;
  logic [TickW-1:0]  phase_rem, phase_rem_next;
  logic [PhaseW-1:0] phase, phase_next;
  logic [PhaseW-1:0] pattern_select, pattern_select_next;
  logic              train_active, train_active_next;
  logic [IdxW-1:0]   train_index, train_index_next;
  logic [StepW-1:0]  train_step, train_step_next;
  logic [TickW-1:0]  step_elapsed, step_elapsed_next;
  logic              pin_register, pin_register_next;

  logic [TickW-1:0]  msec_inc;
  logic [TickW-1:0]  rem_inc;
  logic [TickW-1:0]  elapsed_inc;
  logic [StepW-1:0]  step_inc;
  logic [StepW-1:0]  train_end;

  always_comb begin
    msec_count_next     = msec_count;
    phase_rem_next      = phase_rem;
    phase_next          = phase;
    pattern_select_next = pattern_select;
    train_active_next   = train_active;
    train_index_next    = train_index;
    train_step_next     = train_step;
    step_elapsed_next   = step_elapsed;
    pin_register_next   = pin_register;

    msec_inc    = (msec_count == TickW'(MsecWrap - 1)) ? '0 : msec_count + TickW'(1);
    rem_inc     = phase_rem + TickW'(1);
    elapsed_inc = step_elapsed + TickW'(1);
    step_inc    = train_step + StepW'(1);
    // train ends once the step reaches 2 * pulses + 1
    train_end   = StepW'({train_index, 1'b1}) + StepW'(2);

    if (fire) begin
      case (cmd.mode)
        MODE_TICK: begin
          msec_count_next = msec_inc;
          // phase = (msec / len) mod phases, tracked incrementally
          if (msec_inc == '0) begin
            phase_rem_next = '0;
            phase_next     = '0;
          end else if (rem_inc == pat_len) begin
            phase_rem_next = '0;
            phase_next     = phase + PhaseW'(1);
          end else begin
            phase_rem_next = rem_inc;
          end
          if (train_active) begin
            step_elapsed_next = elapsed_inc;
            if (elapsed_inc >= pul_len) begin
              step_elapsed_next = '0;
              train_step_next   = step_inc;
              if (step_inc >= train_end) begin
                train_active_next = 1'b0;
                pin_register_next = ~polarity;
              end else begin
                pin_register_next = (step_inc[0] == polarity);
              end
            end
          end else begin
            pin_register_next = (PATTERN_ROM[pattern_select][phase_next] == polarity);
          end
        end
        MODE_PATTERN: begin
          pattern_select_next = cmd.value[PhaseW-1:0];
        end
        MODE_PULSE: begin
          train_index_next  = pulse_index(cmd.value);
          train_step_next   = '0;
          step_elapsed_next = '0;
          train_active_next = 1'b1;
          pin_register_next = ~polarity;
        end
        default: begin
        end
      endcase
    end else if (realign.done) begin
      // new pattern step length: load the divided position
      phase_rem_next = realign.rem;
      phase_next     = realign.phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msec_count     <= '0;
      phase_rem      <= '0;
      phase          <= '0;
      pattern_select <= '0;
      train_active   <= 1'b0;
      train_index    <= '0;
      train_step     <= '0;
      step_elapsed   <= '0;
      pin_register   <= 1'b0;
    end else begin
      msec_count     <= msec_count_next;
      phase_rem      <= phase_rem_next;
      phase          <= phase_next;
      pattern_select <= pattern_select_next;
      train_active   <= train_active_next;
      train_index    <= train_index_next;
      train_step     <= train_step_next;
      step_elapsed   <= step_elapsed_next;
      pin_register   <= pin_register_next;
    end
  end

  assign msec                = msec_count;
  assign res_next.pin_level  = pin_register_next;
  assign res_next.pulse_busy = train_active_next;

endmodule

[hdl/led_ppd_skid.sv]
// Two-entry result buffer that decouples the result channel from command intake.
module led_ppd_skid
  import led_ppd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic space,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic out_valid;
  res_t out_data;
  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop = out_valid && res_ready;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  assign space     = !skid_valid;
  assign res_valid = out_valid;
  assign res       = out_data;

endmodule

[hdl/led_pattern_and_pulse_driver_core.sv]
// Throughput: one command beat per cycle while the result buffer has space and no
// realignment runs; each taken beat's result is registered in the two-entry buffer.
// A write to pattern_step_ticks holds off commands while a bit-serial divider
// (one quotient bit per cycle) realigns the pattern phase.
// Reset (synchronous): counters cleared, steady-on pattern, no pulse train,
// polarity 0, pattern step 125 ms, pulse step 50 ms.
module led_pattern_and_pulse_driver_core
  import led_ppd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cmd_t                cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic             active_polarity;
  logic [TickW-1:0] pattern_step_ticks;
  logic [TickW-1:0] pulse_step_ticks;
  logic             recalc;
  logic             cfg_wr;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [TickW-1:0] pat_len;
  logic [TickW-1:0] pul_len;
  logic             div_busy;
  div_res_t         div_res;
  logic [TickW-1:0] msec;
  res_t             res_next;
  logic             space;
  logic             fire;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CfgAddrW-1:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_polarity    <= 1'b0;
      pattern_step_ticks <= PatternStepReset;
      pulse_step_ticks   <= PulseStepReset;
      recalc             <= 1'b0;
    end else begin
      recalc <= cfg_wr && (cfg_idx == REG_PATTERN_STEP);
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_POLARITY:     active_polarity    <= pwdata[0];
          REG_PATTERN_STEP: pattern_step_ticks <= pwdata[TickW-1:0];
          REG_PULSE_STEP:   pulse_step_ticks   <= pwdata[TickW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_POLARITY:     prdata = {31'd0, active_polarity};
      REG_PATTERN_STEP: prdata = {{(32 - TickW){1'b0}}, pattern_step_ticks};
      REG_PULSE_STEP:   prdata = {{(32 - TickW){1'b0}}, pulse_step_ticks};
      default:          prdata = '0;
    endcase
  end

  // A zero step length acts as one
  assign pat_len = (pattern_step_ticks == '0) ? TickW'(1) : pattern_step_ticks;
  assign pul_len = (pulse_step_ticks == '0) ? TickW'(1) : pulse_step_ticks;

  assign cmd_ready = space && !recalc && !div_busy;
  assign fire      = cmd_valid && cmd_ready;

  led_ppd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (recalc),
    .dividend (msec),
    .divisor  (pat_len),
    .busy     (div_busy),
    .result   (div_res)
  );

  led_ppd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .cmd      (cmd),
    .polarity (active_polarity),
    .pat_len  (pat_len),
    .pul_len  (pul_len),
    .realign  (div_res),
    .msec     (msec),
    .res_next (res_next)
  );

  led_ppd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (res_next),
    .space     (space),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
